@@ sv/fds_pkg.sv @@
// ----------------------------------------------------------------------------
// fds_pkg
// Shared types, widths and codes of the finite difference stencil core.
// ----------------------------------------------------------------------------
package fds_pkg;

  // Sample width, two's complement Q8.8 at the default width.
  localparam int unsigned SAMPLE_WIDTH = 16;
  // A stencil sum is at most 64 samples in magnitude.
  localparam int unsigned SUM_W        = SAMPLE_WIDTH + 7;
  localparam int unsigned SCALE_W      = 24;
  localparam int unsigned SITE_W       = 16;
  localparam int unsigned OUT_W        = 32;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 24;

  // Product of a sum and an unsigned Q8.16 scale.
  localparam int unsigned PROD_W = SUM_W + SCALE_W + 1;
  // Quotient width after the smallest divisor shift.
  localparam int unsigned QW     = PROD_W - 16;
  // Dividend of the divide-by-three step and its biased, non-negative form.
  localparam int unsigned XW     = PROD_W - 18;
  localparam int unsigned YW     = XW + 1;
  localparam int unsigned DIV3_SHIFT = YW + 2;
  localparam logic [63:0] DIV3_MUL    = ((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3;
  localparam logic [63:0] DIV3_BIAS   = 64'd3 << (XW - 1);
  localparam logic [63:0] DIV3_OFFSET = 64'd1 << (XW - 1);

  // Rounding offsets (half the divisor) and shifts for each divisor.
  localparam int RND_ADD_HALF     = 65536;
  localparam int RND_ADD_ONE      = 32768;
  localparam int RND_ADD_TWELFTH  = 393216;
  localparam int RND_SH_HALF      = 17;
  localparam int RND_SH_ONE       = 16;
  localparam int RND_SH_TWELFTH   = 18;

  localparam int unsigned WINDOW_DEPTH = 4;
  localparam int unsigned JOB_MAX      = 3;
  localparam int unsigned JOB_IDX_W    = 2;
  localparam int unsigned MIN_SITES    = 3;

  localparam logic [SITE_W-1:0]  SITE_COUNT_RST = 16'd1024;
  localparam logic [SCALE_W-1:0] INV_STEP_RST   = 24'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SITE_COUNT   = 3'd0,
    CFG_STENCIL_MODE = 3'd1,
    CFG_PERIODIC     = 3'd2,
    CFG_INV_STEP     = 3'd3,
    CFG_INV_STEP_SQ  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_FIRST3  = 2'd0,
    MODE_SECOND3 = 2'd1,
    MODE_FIRST5  = 2'd2,
    MODE_SECOND5 = 2'd3
  } mode_e;

  // Divisor applied to a product: 2, 1 or 12 times 2^16.
  typedef enum logic [1:0] {
    KIND_HALF    = 2'd0,
    KIND_ONE     = 2'd1,
    KIND_TWELFTH = 2'd2
  } kind_e;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]        sum_t;
  typedef logic [SCALE_W-1:0]             scale_t;
  typedef logic [SITE_W-1:0]              site_t;

  typedef struct packed {
    site_t  site_count;
    mode_e  mode;
    logic   periodic;
    scale_t inv_step;
    scale_t inv_step_sq;
  } cfg_t;

  // One pending result: its stencil sum and how to scale it.
  typedef struct packed {
    sum_t   sum;
    scale_t scale;
    kind_e  kind;
    site_t  site;
    logic   last;
  } job_t;

  typedef struct packed {
    kind_e kind;
    site_t site;
    logic  last;
  } meta_t;

  function automatic sum_t ext(sample_t v);
    return sum_t'(v);
  endfunction

endpackage

@@ sv/fds_cell.sv @@
// ----------------------------------------------------------------------------
// fds_cell
// One tap of the sample window; passes its sample to the next tap on a shift.
// ----------------------------------------------------------------------------
module fds_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  fds_pkg::sample_t d_i,
  output fds_pkg::sample_t q_o
);

  fds_pkg::sample_t tap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else if (shift_i) begin
      tap_q <= d_i;
    end
  end

  assign q_o = tap_q;

endmodule

@@ sv/fds_front.sv @@
// ----------------------------------------------------------------------------
// fds_front
// Sample window, site counter and stencil sums; issues up to three jobs per
// sample, one per cycle while the arithmetic pipeline is ready.
// ----------------------------------------------------------------------------
module fds_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  fds_pkg::sample_t sample_i,
  input  fds_pkg::cfg_t    cfg_i,
  output fds_pkg::job_t    job_o,
  output logic             job_valid_o,
  input  logic             job_ready_i
);

  fds_pkg::sample_t win [fds_pkg::WINDOW_DEPTH];
  fds_pkg::sample_t head0_q, head1_q;
  fds_pkg::site_t   site_index_q, site_index_d;
  fds_pkg::site_t   k, neff;
  logic             last;
  logic             accept, issue_fire;

  fds_pkg::sum_t es, e0, e1, e2, e3, eh0, eh1;
  fds_pkg::job_t cand [fds_pkg::JOB_MAX];
  logic [fds_pkg::JOB_MAX-1:0] cv;
  fds_pkg::job_t jobs_q [fds_pkg::JOB_MAX];
  fds_pkg::job_t jobs_d [fds_pkg::JOB_MAX];
  logic [fds_pkg::JOB_IDX_W-1:0] rem_q, rem_d, idx_q, idx_d, n;
  logic second;

  // The window is a row of taps; the newest sample enters tap 0.
  for (genvar i = 0; i < fds_pkg::WINDOW_DEPTH; i++) begin : g_win
    if (i == 0) begin : g_head
      fds_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(accept),
        .d_i    (sample_i),
        .q_o    (win[i])
      );
    end else begin : g_tail
      fds_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(accept),
        .d_i    (win[i-1]),
        .q_o    (win[i])
      );
    end
  end

  assign k  = site_index_q;
  assign es = fds_pkg::ext(sample_i);
  assign e0 = fds_pkg::ext(win[0]);
  assign e1 = fds_pkg::ext(win[1]);
  assign e2 = fds_pkg::ext(win[2]);
  assign e3 = fds_pkg::ext(win[3]);
  assign eh0 = fds_pkg::ext(head0_q);
  assign eh1 = fds_pkg::ext(head1_q);

  always_comb begin
    neff = (cfg_i.site_count < fds_pkg::SITE_W'(fds_pkg::MIN_SITES)) ?
           fds_pkg::SITE_W'(fds_pkg::MIN_SITES) : cfg_i.site_count;
    last = (k >= (neff - fds_pkg::SITE_W'(1)));
  end

  // Candidate jobs: the interior site, then the sites flushed by a final sample.
  always_comb begin
    second = (cfg_i.mode == fds_pkg::MODE_SECOND5);
    for (int j = 0; j < fds_pkg::JOB_MAX; j++) begin
      cand[j] = '0;
    end
    cv = '0;
    case (cfg_i.mode)
      fds_pkg::MODE_FIRST3: begin
        for (int j = 0; j < fds_pkg::JOB_MAX; j++) begin
          cand[j].kind  = fds_pkg::KIND_HALF;
          cand[j].scale = cfg_i.inv_step;
        end
        cv[0] = (k >= fds_pkg::SITE_W'(2));
        cand[0].site = k - fds_pkg::SITE_W'(2);
        // Site zero uses the one-sided forward stencil.
        cand[0].sum = (k == fds_pkg::SITE_W'(2)) ?
                      ((e0 <<< 2) - ((e1 <<< 1) + e1) - es) : (e0 - e2);
        cv[1] = last;
        cand[1].site = k - fds_pkg::SITE_W'(1);
        cand[1].sum  = es - e1;
        cv[2] = last;
        cand[2].site = k;
        cand[2].sum  = e1 - (e0 <<< 2) + ((es <<< 1) + es);
      end
      fds_pkg::MODE_SECOND3: begin
        for (int j = 0; j < fds_pkg::JOB_MAX; j++) begin
          cand[j].kind  = fds_pkg::KIND_ONE;
          cand[j].scale = cfg_i.inv_step_sq;
        end
        // With wrap-around, site zero waits for the end of the line.
        cv[0] = (k >= fds_pkg::SITE_W'(1)) &&
                !((k == fds_pkg::SITE_W'(1)) && cfg_i.periodic);
        cand[0].site = k - fds_pkg::SITE_W'(1);
        cand[0].sum  = (k == fds_pkg::SITE_W'(1)) ? '0 : (e1 + es - (e0 <<< 1));
        cv[1] = last;
        cand[1].site = k;
        cand[1].sum  = cfg_i.periodic ? (e0 + eh0 - (es <<< 1)) : '0;
        cv[2] = last && cfg_i.periodic;
        cand[2].site = '0;
        cand[2].sum  = es + eh1 - (eh0 <<< 1);
      end
      default: begin
        for (int j = 0; j < fds_pkg::JOB_MAX; j++) begin
          cand[j].kind  = fds_pkg::KIND_TWELFTH;
          cand[j].scale = second ? cfg_i.inv_step_sq : cfg_i.inv_step;
        end
        cv[0] = (k >= fds_pkg::SITE_W'(2));
        cand[0].site = k - fds_pkg::SITE_W'(2);
        if (k >= fds_pkg::SITE_W'(4)) begin
          cand[0].sum = second ?
            (((e2 + e0) <<< 4) - (e3 + es) - ((e1 <<< 5) - (e1 <<< 1))) :
            ((e3 - es) - ((e2 - e0) <<< 3));
        end
        cv[1] = last;
        cand[1].site = k - fds_pkg::SITE_W'(1);
        cv[2] = last;
        cand[2].site = k;
      end
    endcase
  end

  // Pack the valid candidates to the front of the issue slot.
  always_comb begin
    if (cv[0]) begin
      jobs_d[0] = cand[0];
      jobs_d[1] = cand[1];
      jobs_d[2] = cand[2];
    end else begin
      jobs_d[0] = cand[1];
      jobs_d[1] = cand[2];
      jobs_d[2] = cand[2];
    end
    n = fds_pkg::JOB_IDX_W'(cv[0]) + fds_pkg::JOB_IDX_W'(cv[1]) +
        fds_pkg::JOB_IDX_W'(cv[2]);
  end

  assign job_valid_o = (rem_q != '0);
  assign issue_fire  = job_valid_o && job_ready_i;
  assign in_stall_o  = !((rem_q == '0) ||
                         (issue_fire && (rem_q == fds_pkg::JOB_IDX_W'(1))));
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    job_o      = jobs_q[idx_q];
    job_o.last = (rem_q == fds_pkg::JOB_IDX_W'(1));
  end

  always_comb begin
    rem_d        = rem_q;
    idx_d        = idx_q;
    site_index_d = site_index_q;
    if (accept) begin
      rem_d        = n;
      idx_d        = '0;
      site_index_d = last ? '0 : (k + fds_pkg::SITE_W'(1));
    end else if (issue_fire) begin
      rem_d = rem_q - fds_pkg::JOB_IDX_W'(1);
      idx_d = (rem_q == fds_pkg::JOB_IDX_W'(1)) ? '0 : (idx_q + fds_pkg::JOB_IDX_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q        <= '0;
      idx_q        <= '0;
      site_index_q <= '0;
    end else begin
      rem_q        <= rem_d;
      idx_q        <= idx_d;
      site_index_q <= site_index_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int j = 0; j < fds_pkg::JOB_MAX; j++) begin
        jobs_q[j] <= jobs_d[j];
      end
      if (k == '0) begin
        head0_q <= sample_i;
      end
      if (k == fds_pkg::SITE_W'(1)) begin
        head1_q <= sample_i;
      end
    end
  end

  // A final sample restarts the line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |=> site_index_q == '0)
    else $error("site index did not restart after the final sample");

  // A final sample in the 3-point first derivative mode always loads three jobs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last && (cfg_i.mode == fds_pkg::MODE_FIRST3)
    |=> rem_q == fds_pkg::JOB_IDX_W'(fds_pkg::JOB_MAX) && idx_q == '0)
    else $error("final sample did not load three jobs");

  // The issue pointer never runs past the loaded jobs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o |-> ({1'b0, idx_q} + {1'b0, rem_q}) <= 3'(fds_pkg::JOB_MAX))
    else $error("issue slot pointer out of range");

endmodule

@@ sv/fds_arith.sv @@
// ----------------------------------------------------------------------------
// fds_arith
// Scale, round, divide and saturate pipeline with an elastic output register.
// ----------------------------------------------------------------------------
module fds_arith (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fds_pkg::job_t                job_i,
  input  logic                         job_valid_i,
  output logic                         job_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [fds_pkg::OUT_W-1:0] derivative_o,
  output fds_pkg::site_t               site_o,
  output logic                         saturated_o,
  output logic                         last_of_run_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic r1, r2, r3, r4, r5;

  fds_pkg::sum_t   sum1_q;
  fds_pkg::scale_t scale1_q;
  fds_pkg::meta_t  meta1_q, meta2_q, meta3_q, meta4_q;

  logic signed [fds_pkg::SCALE_W:0]  scale_s;
  logic signed [fds_pkg::PROD_W-1:0] prod_d, prod2_q;
  logic signed [fds_pkg::PROD_W-1:0] add_half, add_one, add_12, bias_s;
  logic signed [fds_pkg::PROD_W-1:0] rnd_half, rnd_one, rnd_12;
  logic signed [fds_pkg::PROD_W-1:0] sh_half, sh_one, sh_12, y_full;
  logic signed [fds_pkg::QW-1:0]     qa_d, qa3_q, q12, q4_d, q4_q;
  logic [fds_pkg::YW-1:0]            y3_q;
  logic [2*fds_pkg::YW+1:0]          prod3;
  logic [fds_pkg::YW-1:0]            q3;
  logic signed [63:0]                qe;
  logic signed [fds_pkg::OUT_W-1:0]  deriv_d, deriv_q;
  logic                              sat_d, sat_q;
  fds_pkg::site_t                    site_q;
  logic                              last_q;

  // Each stage takes new data when it is empty or its successor moves.
  assign r5 = !v5_q || !out_stall_i;
  assign r4 = !v4_q || r5;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign job_ready_o = r1;

  // Product of the stencil sum and the unsigned scale.
  assign scale_s = {1'b0, scale1_q};
  assign prod_d  = sum1_q * scale_s;

  // Add half the divisor, then shift; the twelfth case divides by three next.
  assign add_half = fds_pkg::PROD_W'(fds_pkg::RND_ADD_HALF);
  assign add_one  = fds_pkg::PROD_W'(fds_pkg::RND_ADD_ONE);
  assign add_12   = fds_pkg::PROD_W'(fds_pkg::RND_ADD_TWELFTH);
  assign bias_s   = $signed(fds_pkg::PROD_W'(fds_pkg::DIV3_BIAS));
  assign rnd_half = prod2_q + add_half;
  assign rnd_one  = prod2_q + add_one;
  assign rnd_12   = prod2_q + add_12;
  assign sh_half  = rnd_half >>> fds_pkg::RND_SH_HALF;
  assign sh_one   = rnd_one >>> fds_pkg::RND_SH_ONE;
  assign sh_12    = rnd_12 >>> fds_pkg::RND_SH_TWELFTH;
  assign y_full   = sh_12 + bias_s;
  assign qa_d     = (meta2_q.kind == fds_pkg::KIND_HALF) ?
                    sh_half[fds_pkg::QW-1:0] : sh_one[fds_pkg::QW-1:0];

  // Floor division by three of the biased value through a reciprocal.
  assign prod3 = (2*fds_pkg::YW+2)'(y3_q) *
                 (2*fds_pkg::YW+2)'(fds_pkg::DIV3_MUL[fds_pkg::YW:0]);
  assign q3    = prod3[2*fds_pkg::YW+1:fds_pkg::DIV3_SHIFT];
  assign q12   = $signed(fds_pkg::QW'(q3)) -
                 $signed(fds_pkg::QW'(fds_pkg::DIV3_OFFSET));
  assign q4_d  = (meta3_q.kind == fds_pkg::KIND_TWELFTH) ? q12 : qa3_q;

  // Clip to the signed 32-bit range.
  always_comb begin
    qe = 64'(q4_q);
    sat_d = 1'b0;
    deriv_d = qe[fds_pkg::OUT_W-1:0];
    if (qe > 64'sd2147483647) begin
      deriv_d = 32'sh7FFF_FFFF;
      sat_d   = 1'b1;
    end else if (qe < -64'sd2147483648) begin
      deriv_d = 32'sh8000_0000;
      sat_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (r1) begin
        v1_q <= job_valid_i;
      end
      if (r2) begin
        v2_q <= v1_q;
      end
      if (r3) begin
        v3_q <= v2_q;
      end
      if (r4) begin
        v4_q <= v3_q;
      end
      if (r5) begin
        v5_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1) begin
      sum1_q   <= job_i.sum;
      scale1_q <= job_i.scale;
      meta1_q  <= '{kind: job_i.kind, site: job_i.site, last: job_i.last};
    end
    if (r2) begin
      prod2_q <= prod_d;
      meta2_q <= meta1_q;
    end
    if (r3) begin
      qa3_q   <= qa_d;
      y3_q    <= y_full[fds_pkg::YW-1:0];
      meta3_q <= meta2_q;
    end
    if (r4) begin
      q4_q    <= q4_d;
      meta4_q <= meta3_q;
    end
    if (r5) begin
      deriv_q <= deriv_d;
      sat_q   <= sat_d;
      site_q  <= meta4_q.site;
      last_q  <= meta4_q.last;
    end
  end

  assign out_valid_o   = v5_q;
  assign derivative_o  = deriv_q;
  assign site_o        = site_q;
  assign saturated_o   = sat_q;
  assign last_of_run_o = last_q;

  // A clipped result sits exactly at one end of the range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (derivative_o == 32'sh7FFF_FFFF) || (derivative_o == 32'sh8000_0000))
    else $error("saturated result not at a range limit");

  // The bias keeps the divide-by-three operand in the upper half of its range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && (meta3_q.kind == fds_pkg::KIND_TWELFTH) |-> y3_q[fds_pkg::YW-1])
    else $error("divide-by-three operand out of range");

  // A taken result with nothing behind it leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !v4_q |=> !out_valid_o)
    else $error("output stage held a stale result");

endmodule

@@ sv/finite_difference_stencil_core.sv @@
// ----------------------------------------------------------------------------
// finite_difference_stencil_core
// Streaming 3- and 5-point first and second derivative of one grid line.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+--------------------------
//   in      | sink      | in_valid_i / in_stall_o    | sample_i
//   out     | source    | out_valid_o / out_stall_i  | derivative_o, site_o,
//           |           |                            | saturated_o, last_of_run_o
//   cfg     | sink      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One sample is taken per cycle while the input is not stalled. A sample that
// completes a line yields up to three results, which leave the issue slot one
// per cycle while the pipeline takes them; the next sample is stalled until the
// last of them leaves the slot. The first result of a sample passes the issue
// slot and the arithmetic pipeline registers before it appears, and any further
// results follow one per cycle unless the output stalls.
// Reset clears the sample window, the site counter, the issue slot and the
// pipeline valid bits, and loads the register defaults.
// A stall on the output fills bubbles in the pipeline first; apart from the
// flush of a final sample, the input is stalled only once every stage between
// the two holds a result.
// ----------------------------------------------------------------------------
module finite_difference_stencil_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Sample stream.
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [fds_pkg::SAMPLE_WIDTH-1:0] sample_i,
  // Result stream.
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [fds_pkg::OUT_W-1:0]      derivative_o,
  output logic [fds_pkg::SITE_W-1:0]            site_o,
  output logic                                  saturated_o,
  output logic                                  last_of_run_o,
  // Register writes.
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [fds_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [fds_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  fds_pkg::site_t  site_count_q;
  fds_pkg::mode_e  stencil_mode_q;
  logic            periodic_q;
  fds_pkg::scale_t inv_step_q;
  fds_pkg::scale_t inv_step_sq_q;
  fds_pkg::cfg_t   cfg;

  fds_pkg::job_t   job;
  logic            job_valid;
  logic            job_ready;

  // Register writes are always taken; an index beyond the register list is
  // accepted and has no effect.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_count_q   <= fds_pkg::SITE_COUNT_RST;
      stencil_mode_q <= fds_pkg::MODE_FIRST3;
      periodic_q     <= 1'b0;
      inv_step_q     <= fds_pkg::INV_STEP_RST;
      inv_step_sq_q  <= fds_pkg::INV_STEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        fds_pkg::CFG_SITE_COUNT: begin
          site_count_q <= cfg_data_i[fds_pkg::SITE_W-1:0];
        end
        fds_pkg::CFG_STENCIL_MODE: begin
          stencil_mode_q <= fds_pkg::mode_e'(cfg_data_i[1:0]);
        end
        fds_pkg::CFG_PERIODIC: begin
          periodic_q <= cfg_data_i[0];
        end
        fds_pkg::CFG_INV_STEP: begin
          inv_step_q <= cfg_data_i[fds_pkg::SCALE_W-1:0];
        end
        fds_pkg::CFG_INV_STEP_SQ: begin
          inv_step_sq_q <= cfg_data_i[fds_pkg::SCALE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = '{
    site_count:  site_count_q,
    mode:        stencil_mode_q,
    periodic:    periodic_q,
    inv_step:    inv_step_q,
    inv_step_sq: inv_step_sq_q
  };

  // The front end keeps the window of past samples as a row of taps, forms
  // the stencil sums for the current sample and hands out one job per cycle while the arithmetic pipeline takes them.
  fds_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .cfg_i      (cfg),
    .job_o      (job),
    .job_valid_o(job_valid),
    .job_ready_i(job_ready)
  );

  // The arithmetic pipeline scales each sum, rounds to nearest with ties
  // upward, divides by the stencil constant and clips to 32 bits.
  fds_arith u_arith (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job),
    .job_valid_i  (job_valid),
    .job_ready_o  (job_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .derivative_o (derivative_o),
    .site_o       (site_o),
    .saturated_o  (saturated_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming finite difference stencil core.
// Grid lines of Q8.8 samples are streamed through all four stencil modes.
// A scoreboard inside the bench computes every expected derivative as each
// sample is taken. Each result the core emits is then compared with the
// oldest expected one. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Stop the run here if the core hangs; this is far above the slowest correct run.
  localparam int CYCLE_LIMIT  = 200000;
  // Cycles to wait after the last expected result. This exceeds the path of a sample
  // through the core, so it also covers a sample that produces no result.
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 236;

  // Divisors applied to sum * scale: 2, 1 and 12, all in Q.16.
  localparam longint DIV_HALF    = 64'sd131072;
  localparam longint DIV_ONE     = 64'sd65536;
  localparam longint DIV_TWELFTH = 64'sd786432;
  localparam longint OUT_MAX     = 64'sd2147483647;
  localparam longint OUT_MIN     = -64'sd2147483648;

  // One derivative as the core should report it.
  typedef struct packed {
    logic signed [fds_pkg::OUT_W-1:0] derivative;
    fds_pkg::site_t                   site;
    logic                             saturated;
    logic                             last;
  } deriv_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_stall_o;
  fds_pkg::sample_t                 sample_i;
  logic                             out_valid_o;
  logic                             out_stall_i;
  logic signed [fds_pkg::OUT_W-1:0] derivative_o;
  fds_pkg::site_t                   site_o;
  logic                             saturated_o;
  logic                             last_of_run_o;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [fds_pkg::CFG_IDX_W-1:0]    cfg_index_i;
  logic [fds_pkg::CFG_DATA_W-1:0]   cfg_data_i;

  // Scoreboard copy of the register file.
  fds_pkg::site_t  reg_site_count;
  fds_pkg::mode_e  reg_mode;
  logic            reg_periodic;
  fds_pkg::scale_t reg_inv_step;
  fds_pkg::scale_t reg_inv_step_sq;

  // Scoreboard copy of the line state: the last four samples (newest
  // first), the first two samples of the line, and the next site index.
  fds_pkg::sample_t history [4];
  fds_pkg::sample_t line_head [2];
  fds_pkg::site_t   next_site;

  // Derivatives that the core still owes, oldest first.
  deriv_t derivs_q [$];

  // When a calm flag is set, that side of the core runs without gaps.
  bit               in_calm;
  bit               out_calm;
  fds_pkg::sample_t prev_sample;

  int mismatches;
  int results_seen;
  int samples_sent;
  int reg_writes;
  int cycle_count;

  finite_difference_stencil_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .derivative_o  (derivative_o),
    .site_o        (site_o),
    .saturated_o   (saturated_o),
    .last_of_run_o (last_of_run_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Scoreboard
  // --------------------------------------------------------------------------

  // Scales a stencil sum, rounds to nearest with ties toward plus infinity,
  // clips to 32 bits, and queues the result for the given site.
  function automatic void push_derivative(longint sum, longint scale, longint divisor,
                                          fds_pkg::site_t site);
    longint num;
    longint quo;
    deriv_t d;
    num = sum * scale + divisor / 2;
    quo = num / divisor;
    // Integer division truncates toward zero; step down to get the floor.
    if ((num % divisor) != 0 && num < 0) begin
      quo = quo - 1;
    end
    d.saturated = 1'b0;
    if (quo > OUT_MAX) begin
      quo = OUT_MAX;
      d.saturated = 1'b1;
    end
    if (quo < OUT_MIN) begin
      quo = OUT_MIN;
      d.saturated = 1'b1;
    end
    d.derivative = quo[fds_pkg::OUT_W-1:0];
    d.site       = site;
    d.last       = 1'b0;
    derivs_q.push_back(d);
  endfunction

  // Works out every derivative that one accepted sample releases and then
  // advances the line state.
  function automatic void predict_derivatives(fds_pkg::sample_t s_in);
    longint         s, w0, w1, w2, w3, h0, h1, sum, scale;
    fds_pkg::site_t k;
    int unsigned    neff;
    bit             last_site;
    bit             second;
    int             size_before;
    deriv_t         tail;
    s  = s_in;
    w0 = history[0];
    w1 = history[1];
    w2 = history[2];
    w3 = history[3];
    h0 = line_head[0];
    h1 = line_head[1];
    k  = next_site;
    // A line is never shorter than three sites.
    neff = (reg_site_count < fds_pkg::MIN_SITES) ? fds_pkg::MIN_SITES : reg_site_count;
    // The count may have been lowered mid-line, so any index at or past the
    // end closes the line.
    last_site   = (k >= neff - 1);
    size_before = derivs_q.size();

    case (reg_mode)
      fds_pkg::MODE_FIRST3: begin
        if (k >= 2) begin
          // Site 0 uses the forward one-sided stencil.
          sum = (k == 2) ? (4 * w0 - 3 * w1 - s) : (w0 - w2);
          push_derivative(sum, reg_inv_step, DIV_HALF, fds_pkg::site_t'(k - 2));
        end
        if (last_site) begin
          push_derivative(s - w1, reg_inv_step, DIV_HALF, fds_pkg::site_t'(k - 1));
          // Last site uses the backward one-sided stencil.
          push_derivative(w1 - 4 * w0 + 3 * s, reg_inv_step, DIV_HALF, k);
        end
      end
      fds_pkg::MODE_SECOND3: begin
        if (k == 1) begin
          // Site 0 is zero, or held back until the line closes when periodic.
          if (!reg_periodic) begin
            push_derivative(0, reg_inv_step_sq, DIV_ONE, fds_pkg::site_t'(0));
          end
        end else if (k > 1) begin
          push_derivative(w1 + s - 2 * w0, reg_inv_step_sq, DIV_ONE,
                          fds_pkg::site_t'(k - 1));
        end
        if (last_site) begin
          sum = reg_periodic ? (w0 + h0 - 2 * s) : 64'sd0;
          push_derivative(sum, reg_inv_step_sq, DIV_ONE, k);
          if (reg_periodic) begin
            push_derivative(s + h1 - 2 * h0, reg_inv_step_sq, DIV_ONE,
                            fds_pkg::site_t'(0));
          end
        end
      end
      default: begin
        second = (reg_mode == fds_pkg::MODE_SECOND5);
        scale  = second ? reg_inv_step_sq : reg_inv_step;
        if (k >= 2) begin
          // The two sites at each end of the line are zero.
          sum = 0;
          if (k >= 4) begin
            sum = second ? (16 * (w2 + w0) - 30 * w1 - (w3 + s))
                         : ((w3 - s) - 8 * (w2 - w0));
          end
          push_derivative(sum, scale, DIV_TWELFTH, fds_pkg::site_t'(k - 2));
        end
        if (last_site) begin
          push_derivative(0, scale, DIV_TWELFTH, fds_pkg::site_t'(k - 1));
          push_derivative(0, scale, DIV_TWELFTH, k);
        end
      end
    endcase

    // The final result of a sample carries the last flag.
    if (derivs_q.size() > size_before) begin
      tail = derivs_q.pop_back();
      tail.last = 1'b1;
      derivs_q.push_back(tail);
    end

    if (k == 0) begin
      line_head[0] = s_in;
    end
    if (k == 1) begin
      line_head[1] = s_in;
    end
    history[3] = history[2];
    history[2] = history[1];
    history[1] = history[0];
    history[0] = s_in;
    next_site  = last_site ? fds_pkg::site_t'(0) : fds_pkg::site_t'(k + 1);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Sends one sample. The gap before it is drawn per transaction. Valid stays
  // high after acceptance, so the caller must either send again or settle.
  task automatic send_sample(fds_pkg::sample_t value);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 19);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    do @(posedge clk_i); while (in_stall_o);
    predict_derivatives(value);
    prev_sample  = value;
    samples_sent = samples_sent + 1;
  endtask

  // Drops the input valid, waits until every expected result has been
  // checked, and then lets the pipeline drain fully.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (derivs_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register write. It is only called while the core is idle.
  task automatic write_reg(fds_pkg::cfg_idx_e idx, logic [fds_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      fds_pkg::CFG_SITE_COUNT:   reg_site_count  = value[fds_pkg::SITE_W-1:0];
      fds_pkg::CFG_STENCIL_MODE: reg_mode        = fds_pkg::mode_e'(value[1:0]);
      fds_pkg::CFG_PERIODIC:     reg_periodic    = value[0];
      fds_pkg::CFG_INV_STEP:     reg_inv_step    = value[fds_pkg::SCALE_W-1:0];
      fds_pkg::CFG_INV_STEP_SQ:  reg_inv_step_sq = value[fds_pkg::SCALE_W-1:0];
      default: ;
    endcase
    reg_writes = reg_writes + 1;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Output backpressure: before each result a random number of stall cycles
  // is drawn. The stall is then dropped until a result has been taken.
  initial begin : result_backpressure
    int hold;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      hold = out_calm ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted transaction on the output is compared
  // field by field with the oldest expected derivative.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    deriv_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (derivs_q.size() == 0) begin
        if (mismatches < 10) begin
          $display("[%0t] Unexpected result: site %0d derivative %0d", $realtime,
                   site_o, derivative_o);
        end
        mismatches = mismatches + 1;
      end else begin
        want = derivs_q.pop_front();
        results_seen = results_seen + 1;
        if (derivative_o !== want.derivative || site_o !== want.site ||
            saturated_o !== want.saturated || last_of_run_o !== want.last) begin
          if (mismatches < 10) begin
            $display("[%0t] Mismatch: expected deriv %0d site %0d sat %0b last %0b",
                     $realtime, want.derivative, want.site, want.saturated, want.last);
            $display("              got      deriv %0d site %0d sat %0b last %0b",
                     derivative_o, site_o, saturated_o, last_of_run_o);
          end
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count = cycle_count + 1;
    end
    $display("Timeout after %0d cycles, %0d results still expected", cycle_count,
             derivs_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Site counts: mostly short lines, some below the minimum of three, some
  // longer, and now and then the largest count, whose line is longer than the whole run.
  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) begin
      return $urandom_range(3, 12);
    end
    if (r < 15) begin
      return $urandom_range(0, 2);
    end
    if (r < 18) begin
      return $urandom_range(13, 48);
    end
    return 65535;
  endfunction

  function automatic int pick_scale();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 24'hFFFFFF;
      2:       return 24'h010000;
      default: return $urandom & 24'hFFFFFF;
    endcase
  endfunction

  // Samples: mostly fully random, some at the field extremes, and some
  // small steps from the previous sample so that the line looks smooth.
  function automatic fds_pkg::sample_t pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      return fds_pkg::sample_t'($urandom);
    end
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0:       return fds_pkg::sample_t'(16'h7FFF);
        1:       return fds_pkg::sample_t'(16'h8000);
        2:       return fds_pkg::sample_t'(16'h0000);
        default: return fds_pkg::sample_t'(16'hFFFF);
      endcase
    end
    return fds_pkg::sample_t'(prev_sample + $urandom_range(0, 127) - 64);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Default registers after reset: a 1024-site first derivative line. Only
  // the opening sites come out, including the forward one-sided site 0.
  task automatic test_reset_defaults();
    send_sample(fds_pkg::sample_t'(16'h7FFF));
    send_sample(fds_pkg::sample_t'(16'h8000));
    send_sample(fds_pkg::sample_t'(16'h7FFF));
    send_sample(fds_pkg::sample_t'(16'h8000));
    settle();
  endtask

  // Count lowered mid-line to a value below three. The next sample is past
  // the end, so it closes the line with three results. After that, one
  // whole line of three sites follows at the largest 1/h.
  task automatic test_short_line();
    write_reg(fds_pkg::CFG_INV_STEP, 24'hFFFFFF);
    write_reg(fds_pkg::CFG_SITE_COUNT, 24'd0);
    send_sample(fds_pkg::sample_t'(16'h0001));
    send_sample(fds_pkg::sample_t'(16'h8000));
    send_sample(fds_pkg::sample_t'(16'h7FFF));
    send_sample(fds_pkg::sample_t'(16'hFFFF));
    settle();
  endtask

  // Second derivative, 3 points, with zero ends and a zero scale.
  task automatic test_second3_ends();
    write_reg(fds_pkg::CFG_STENCIL_MODE, fds_pkg::CFG_DATA_W'(fds_pkg::MODE_SECOND3));
    write_reg(fds_pkg::CFG_PERIODIC, 24'd0);
    write_reg(fds_pkg::CFG_INV_STEP_SQ, 24'd0);
    write_reg(fds_pkg::CFG_SITE_COUNT, 24'd4);
    send_sample(fds_pkg::sample_t'(16'h7FFF));
    send_sample(fds_pkg::sample_t'(16'h8000));
    send_sample(fds_pkg::sample_t'(16'h0000));
    send_sample(fds_pkg::sample_t'(16'h0001));
    settle();
  endtask

  // Periodic wrap: site 0 is held back and comes last on the final sample.
  task automatic test_second3_periodic();
    write_reg(fds_pkg::CFG_PERIODIC, 24'd1);
    write_reg(fds_pkg::CFG_INV_STEP_SQ, 24'hFFFFFF);
    send_sample(fds_pkg::sample_t'(16'h8000));
    send_sample(fds_pkg::sample_t'(16'h7FFF));
    send_sample(fds_pkg::sample_t'(16'h8000));
    send_sample(fds_pkg::sample_t'(16'h7FFF));
    settle();
  endtask

  // Five-point first derivative on the shortest line with an interior site.
  // The periodic bit is still set and must have no effect here.
  task automatic test_first5();
    write_reg(fds_pkg::CFG_STENCIL_MODE, fds_pkg::CFG_DATA_W'(fds_pkg::MODE_FIRST5));
    write_reg(fds_pkg::CFG_SITE_COUNT, 24'd5);
    write_reg(fds_pkg::CFG_INV_STEP, 24'd1);
    send_sample(fds_pkg::sample_t'(16'h0000));
    send_sample(fds_pkg::sample_t'(16'h7FFF));
    send_sample(fds_pkg::sample_t'(16'h8000));
    send_sample(fds_pkg::sample_t'(16'h7FFF));
    send_sample(fds_pkg::sample_t'(16'hFFFF));
    settle();
  endtask

  task automatic test_second5();
    write_reg(fds_pkg::CFG_STENCIL_MODE, fds_pkg::CFG_DATA_W'(fds_pkg::MODE_SECOND5));
    send_sample(fds_pkg::sample_t'(16'h8000));
    send_sample(fds_pkg::sample_t'(16'h7FFF));
    send_sample(fds_pkg::sample_t'(16'h8000));
    send_sample(fds_pkg::sample_t'(16'h7FFF));
    send_sample(fds_pkg::sample_t'(16'h8000));
    settle();
  endtask

  // Random phases. Each phase rewrites a random set of registers while the
  // core is idle and then streams samples. Usually the phase runs to the end
  // of the current line. Sometimes only part of the line is sent, so the next
  // phase changes the mode or lowers the count in the middle of a line.
  task automatic test_random_lines();
    int          sent;
    int          remain;
    int          len;
    int unsigned neff;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        write_reg(fds_pkg::CFG_SITE_COUNT, fds_pkg::CFG_DATA_W'(pick_count()));
      end
      if ($urandom_range(0, 2) != 0) begin
        write_reg(fds_pkg::CFG_STENCIL_MODE, fds_pkg::CFG_DATA_W'($urandom_range(0, 3)));
      end
      if ($urandom_range(0, 2) == 0) begin
        write_reg(fds_pkg::CFG_PERIODIC, fds_pkg::CFG_DATA_W'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(fds_pkg::CFG_INV_STEP, fds_pkg::CFG_DATA_W'(pick_scale()));
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(fds_pkg::CFG_INV_STEP_SQ, fds_pkg::CFG_DATA_W'(pick_scale()));
      end
      neff   = (reg_site_count < fds_pkg::MIN_SITES) ? fds_pkg::MIN_SITES : reg_site_count;
      remain = (next_site >= neff - 1) ? 1 : int'(neff - next_site);
      len    = remain;
      if (remain > 40 || $urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, (remain < 20) ? remain : 20);
      end
      repeat (len) send_sample(pick_sample());
      sent = sent + len;
      settle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // Every input of the core is driven to a known value from time zero.
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_calm     = 1'b0;
    out_calm    = 1'b0;
    prev_sample = '0;
    mismatches   = 0;
    results_seen = 0;
    samples_sent = 0;
    reg_writes   = 0;

    // The scoreboard starts from the reset state of the core.
    reg_site_count  = fds_pkg::SITE_COUNT_RST;
    reg_mode        = fds_pkg::MODE_FIRST3;
    reg_periodic    = 1'b0;
    reg_inv_step    = fds_pkg::INV_STEP_RST;
    reg_inv_step_sq = fds_pkg::INV_STEP_RST;
    history         = '{default: '0};
    line_head       = '{default: '0};
    next_site       = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_short_line();
    test_second3_ends();
    test_second3_periodic();
    test_first5();
    test_second5();
    test_random_lines();

    settle();
    if (derivs_q.size() != 0) begin
      $display("%0d expected results never arrived", derivs_q.size());
      mismatches = mismatches + 1;
    end

    $display("Streamed %0d samples across all four stencil modes, with %0d register writes.",
             samples_sent, reg_writes);
    $display("Checked %0d derivatives in %0d cycles, %0d mismatches.", results_seen,
             cycle_count, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/fds_pkg.sv
sv/fds_cell.sv
sv/fds_front.sv
sv/fds_arith.sv
sv/finite_difference_stencil_core.sv
bench/tb_top.sv
